[rtl/tlbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_pkg
// Shared widths, defaults and controller/datapath interface types for the
// fully associative translation buffer.
// ----------------------------------------------------------------------------
package tlbl_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int PAGE_W      = 8;
  localparam int FRAME_W     = 8;
  localparam int TIME_W      = 16;
  localparam int SLOT_W      = 4;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic compare;   // register match and free vectors
    logic lookup;    // stamp matching entries, read frame, set result
    logic wr_free;   // insert into lowest free slot
    logic wr_fifo;   // insert at FIFO pointer
    logic wr_lru;    // insert at least recently used slot
    logic load_out;  // move result into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mode;
    logic any_free;
    logic policy_lru;
  } sts_t;

endpackage

[rtl/tlb_lookup_fifo_lru_replace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_lookup_fifo_lru_replace
// Fully associative translation buffer with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  in_mode, in_page_number, in_frame_number,
//                                in_access_time
//  out      out_valid/out_stall  out_hit, out_frame_found, out_slot_index
//  cfg      cfg_we               cfg_wdata (policy_lru)
//
//  Lookup and insert with a free slot or FIFO victim step through accept,
//  compare, evaluate and output load.
//  LRU insert into a full buffer adds a wait for the registered minimum
//  tree over the time stamps before the write.
//  Synchronous reset clears valid bits, stamps, FIFO pointer and policy.
//  A stalled output holds the block in its final step; the next item is
//  accepted while a finished result is still waiting to be taken.
// ----------------------------------------------------------------------------
module tlb_lookup_fifo_lru_replace import tlbl_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [FRAME_W-1:0] in_frame_number,
  input  logic [TIME_W-1:0]  in_access_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [FRAME_W-1:0] out_frame_found,
  output logic [SLOT_W-1:0]  out_slot_index
);

  cmd_t cmd;
  sts_t sts;

  tlbl_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlbl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_mode),
    .in_page_number  (in_page_number),
    .in_frame_number (in_frame_number),
    .in_access_time  (in_access_time),
    .out_hit         (out_hit),
    .out_frame_found (out_frame_found),
    .out_slot_index  (out_slot_index)
  );

`ifndef SYNTH
  // an accepted item keeps the input side busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while item in progress");

  // a result only appears out of the final step of an item
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without item in progress");

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // inserts never report a hit
  a_insert_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_free || cmd.wr_fifo || cmd.wr_lru) |-> ##2 (!out_valid || !out_hit ||
      !$past(cmd.load_out)))
    else $error("insert reported a hit");
`endif

endmodule

[rtl/tlbl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tlbl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_dp
// Datapath: entry cells with parallel page compare, frame RAM, stamp cells,
// registered minimum tree for LRU victim choice, result and output registers.
// ----------------------------------------------------------------------------
module tlbl_dp import tlbl_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_mode,
  input  logic [PAGE_W-1:0]  in_page_number,
  input  logic [FRAME_W-1:0] in_frame_number,
  input  logic [TIME_W-1:0]  in_access_time,
  output logic               out_hit,
  output logic [FRAME_W-1:0] out_frame_found,
  output logic [SLOT_W-1:0]  out_slot_index
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LEAVES = 1 << IDX_W;

  // captured item
  logic               mode_r;
  logic [PAGE_W-1:0]  page_r;
  logic [FRAME_W-1:0] frame_r;
  logic [TIME_W-1:0]  time_r;

  logic               policy_r;
  logic [ENTRIES-1:0] valid_r;
  logic [PAGE_W-1:0]  page_cell_r [ENTRIES];
  logic [TIME_W-1:0]  stamp_r [ENTRIES];
  logic [IDX_W-1:0]   fifo_ptr_r;

  logic [ENTRIES-1:0] match_r;
  logic [ENTRIES-1:0] free_r;
  logic [ENTRIES-1:0] match_nxt;

  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   tree_idx;
  logic [IDX_W-1:0]   wr_slot;
  logic               wr_en;
  logic [ENTRIES-1:0] wr_sel;

  logic               res_hit_r;
  logic [IDX_W-1:0]   res_slot_r;
  logic [FRAME_W-1:0] ram_q;

  logic               out_hit_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      page_r  <= in_page_number;
      frame_r <= in_frame_number;
      time_r  <= in_access_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b0;
    end else if (cfg_we) begin
      policy_r <= cfg_wdata;
    end
  end

  // parallel compare against every valid entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (page_cell_r[i] == page_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      match_r <= match_nxt;
      free_r  <= ~valid_r;
    end
  end

  // highest matching slot wins; lowest free slot is filled first
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign sts.mode       = mode_r;
  assign sts.any_free   = |free_r;
  assign sts.policy_lru = policy_r;

  assign wr_en = cmd.wr_free | cmd.wr_fifo | cmd.wr_lru;

  always_comb begin
    priority if (cmd.wr_free) begin
      wr_slot = free_idx;
    end else if (cmd.wr_fifo) begin
      wr_slot = fifo_ptr_r;
    end else begin
      wr_slot = tree_idx;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      wr_sel[i] = wr_en && (wr_slot == IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_r | wr_sel;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_sel[i]) begin
        page_cell_r[i] <= page_r;
      end
    end
  end

  // stamps: every hit entry on lookup, written slot on an LRU-mode insert
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (!rst_n) begin
        stamp_r[i] <= '0;
      end else if ((cmd.lookup && match_r[i]) || (wr_sel[i] && policy_r)) begin
        stamp_r[i] <= time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_ptr_r <= '0;
    end else if (cmd.wr_fifo) begin
      fifo_ptr_r <= (fifo_ptr_r == IDX_W'(ENTRIES - 1)) ? '0 : fifo_ptr_r + 1'b1;
    end
  end

  tlbl_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (ENTRIES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_slot),
    .wdata (frame_r),
    .re    (cmd.lookup),
    .raddr (hit_idx),
    .rdata (ram_q)
  );

  // ---- registered minimum tree over stamps, ties go to the lower slot ----
  logic [TIME_W-1:0] leaf_st [LEAVES];
  logic [IDX_W-1:0]  leaf_ix [LEAVES];
  logic [TIME_W-1:0] tr_st_r [1:IDX_W][LEAVES];
  logic [IDX_W-1:0]  tr_ix_r [1:IDX_W][LEAVES];

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < ENTRIES) begin : g_real
      assign leaf_st[j] = stamp_r[j];
    end else begin : g_pad
      assign leaf_st[j] = '1;
    end
    assign leaf_ix[j] = IDX_W'(j);
  end

  for (genvar l = 1; l <= IDX_W; l++) begin : g_lvl
    for (genvar n = 0; n < (LEAVES >> l); n++) begin : g_node
      logic [TIME_W-1:0] ls;
      logic [TIME_W-1:0] rs;
      logic [IDX_W-1:0]  li;
      logic [IDX_W-1:0]  ri;
      if (l == 1) begin : g_from_leaf
        assign ls = leaf_st[2*n];
        assign rs = leaf_st[2*n+1];
        assign li = leaf_ix[2*n];
        assign ri = leaf_ix[2*n+1];
      end else begin : g_from_lvl
        assign ls = tr_st_r[l-1][2*n];
        assign rs = tr_st_r[l-1][2*n+1];
        assign li = tr_ix_r[l-1][2*n];
        assign ri = tr_ix_r[l-1][2*n+1];
      end
      always_ff @(posedge clk) begin
        if (rs < ls) begin
          tr_st_r[l][n] <= rs;
          tr_ix_r[l][n] <= ri;
        end else begin
          tr_st_r[l][n] <= ls;
          tr_ix_r[l][n] <= li;
        end
      end
    end
  end

  assign tree_idx = tr_ix_r[IDX_W][0];

  // ---- result and output registers ----
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      res_hit_r  <= |match_r;
      res_slot_r <= hit_idx;
    end else if (wr_en) begin
      res_hit_r  <= 1'b0;
      res_slot_r <= wr_slot;
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, res_slot_r};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r   <= res_hit_r;
      out_frame_r <= res_hit_r ? ram_q : '0;
      out_slot_r  <= slot_ext[SLOT_W-1:0];
    end
  end

  assign out_hit         = out_hit_r;
  assign out_frame_found = out_frame_r;
  assign out_slot_index  = out_slot_r;

endmodule

[rtl/tlbl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbl_ctrl
// Controller: sequences compare, lookup or insert, LRU tree wait and the
// handoff to the output register.
// ----------------------------------------------------------------------------
module tlbl_ctrl import tlbl_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int LVL   = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(LVL + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_TREE = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (!sts.mode) begin
          cmd.lookup = 1'b1;
          state_nxt  = ST_FIN;
        end else if (sts.any_free) begin
          cmd.wr_free = 1'b1;
          state_nxt   = ST_FIN;
        end else if (!sts.policy_lru) begin
          cmd.wr_fifo = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_TREE;
        end
      end
      ST_TREE: begin
        // wait until the minimum has passed every tree level
        if (cnt_r == CNT_W'(LVL)) begin
          cmd.wr_lru = 1'b1;
          state_nxt  = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
